// ===== design/http_header_line_splitter_assert.svh =====
// Assertion macros for the HTTP header line splitter.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef HTTP_HEADER_LINE_SPLITTER_ASSERT_SVH
`define HTTP_HEADER_LINE_SPLITTER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define HHLS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define HHLS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define HHLS_ASSERT_IMP(lbl, ante, cons, msg)
`define HHLS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== design/hhls_pkg.sv =====
// Shared types, status codes and character constants for the header line splitter.
// No dependencies.
package hhls_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_COLON = 2'd1,
        STATUS_TOO_LONG = 2'd2
    } hhls_status_t;

    // Character codes
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SP    = 8'h20;
    localparam logic [7:0] CHAR_HT    = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    // Output field widths
    localparam int FIELD_LEN_W   = 13;
    localparam int VALUE_START_W = 14;
    localparam int VALUE_LEN_W   = 13;

    // One result transaction
    typedef struct packed {
        hhls_status_t             status;
        logic [FIELD_LEN_W-1:0]   field_len;
        logic [VALUE_START_W-1:0] value_start;
        logic [VALUE_LEN_W-1:0]   value_len;
    } hhls_result_t;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CHAR_SP) || (b == CHAR_HT);
    endfunction

    function automatic logic is_trailing(input logic [7:0] b);
        return is_blank(b) || (b == CHAR_CR) || (b == CHAR_LF);
    endfunction

endpackage

// ===== design/hhls_tracker.sv =====
// Per-line scan state: colon, value start and trimmed value end tracking.
// Depends on hhls_pkg.
module hhls_tracker
    import hhls_pkg::*;
#(
    parameter int MAX_LINE = 8192
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic [7:0]   data_byte,
    input  logic         last_byte,
    output hhls_result_t result
);

    localparam int POS_W = $clog2(MAX_LINE + 1);
    localparam int EXT_W = (POS_W > VALUE_START_W) ? POS_W : VALUE_START_W;
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LINE);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             colon_seen_reg, colon_seen_next;
    logic [POS_W-1:0] colon_off_reg, colon_off_next;
    logic             start_seen_reg, start_seen_next;
    logic [POS_W-1:0] start_off_reg, start_off_next;
    logic [POS_W-1:0] end_off_reg, end_off_next;
    logic             too_long_reg, too_long_next;

    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] vlen;
    logic [EXT_W-1:0] flen_ext, vstart_ext, vlen_ext;

    assign pos_inc = pos_reg + 1'b1;

    // State update for the byte in flight
    always_comb
    begin
        pos_next        = pos_reg;
        colon_seen_next = colon_seen_reg;
        colon_off_next  = colon_off_reg;
        start_seen_next = start_seen_reg;
        start_off_next  = start_off_reg;
        end_off_next    = end_off_reg;
        too_long_next   = too_long_reg;
        if (too_long_reg || (pos_reg >= MAX_POS))
        begin
            too_long_next = 1'b1;
        end
        else
        begin
            if (!colon_seen_reg)
            begin
                if (data_byte == CHAR_COLON)
                begin
                    colon_seen_next = 1'b1;
                    colon_off_next  = pos_reg;
                end
            end
            else if (!start_seen_reg)
            begin
                if (!is_blank(data_byte))
                begin
                    start_seen_next = 1'b1;
                    start_off_next  = pos_reg;
                    end_off_next    = is_trailing(data_byte) ? pos_reg : pos_inc;
                end
            end
            else if (!is_trailing(data_byte))
            begin
                end_off_next = pos_inc;
            end
            pos_next = pos_inc;
        end
    end

    // Result built from the updated state
    assign vlen       = end_off_next - start_off_next;
    assign flen_ext   = EXT_W'(colon_off_next);
    assign vstart_ext = start_seen_next ? EXT_W'(start_off_next) : EXT_W'(pos_next);
    assign vlen_ext   = start_seen_next ? EXT_W'(vlen) : '0;

    always_comb
    begin
        result = '0;
        if (too_long_next)
        begin
            result.status = STATUS_TOO_LONG;
        end
        else if (!colon_seen_next || (colon_off_next == '0))
        begin
            result.status = STATUS_NO_COLON;
        end
        else
        begin
            result.status      = STATUS_OK;
            result.field_len   = flen_ext[FIELD_LEN_W-1:0];
            result.value_start = vstart_ext[VALUE_START_W-1:0];
            result.value_len   = vlen_ext[VALUE_LEN_W-1:0];
        end
    end

    // State registers; the last byte returns the scan to its idle state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            colon_seen_reg <= 1'b0;
            colon_off_reg  <= '0;
            start_seen_reg <= 1'b0;
            start_off_reg  <= '0;
            end_off_reg    <= '0;
            too_long_reg   <= 1'b0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                pos_reg        <= '0;
                colon_seen_reg <= 1'b0;
                colon_off_reg  <= '0;
                start_seen_reg <= 1'b0;
                start_off_reg  <= '0;
                end_off_reg    <= '0;
                too_long_reg   <= 1'b0;
            end
            else
            begin
                pos_reg        <= pos_next;
                colon_seen_reg <= colon_seen_next;
                colon_off_reg  <= colon_off_next;
                start_seen_reg <= start_seen_next;
                start_off_reg  <= start_off_next;
                end_off_reg    <= end_off_next;
                too_long_reg   <= too_long_next;
            end
        end
    end

endmodule

// ===== design/http_header_line_splitter.sv =====
// A result is built from its last byte in the input register and loaded into the output register.
// Throughput: one byte per cycle; the input register, scan state and output register
// each advance every cycle unless a finished result is held by out_stall.
// Reset (rst_n, async, active low) empties both registers and clears the scan state.
// Depends on hhls_pkg, hhls_tracker and http_header_line_splitter_assert.svh.
`include "http_header_line_splitter_assert.svh"

module http_header_line_splitter
    import hhls_pkg::*;
#(
    parameter int MAX_LINE = 8192
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [7:0]               data_byte,
    input  logic                     last_byte,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               status,
    output logic [FIELD_LEN_W-1:0]   field_len,
    output logic [VALUE_START_W-1:0] value_start,
    output logic [VALUE_LEN_W-1:0]   value_len
);

    logic         s1_valid_reg;
    logic [7:0]   s1_data_reg;
    logic         s1_last_reg;
    logic         out_valid_reg;
    hhls_result_t out_reg;
    hhls_result_t result;
    logic         out_free;
    logic         proc_go;
    logic         in_fire;

    // Handshake: a byte without a result never waits on the output side
    assign out_free = !out_valid_reg || !out_stall;
    assign proc_go  = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_stall = s1_valid_reg && !proc_go;
    assign in_fire  = in_valid && !in_stall;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (proc_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_data_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
    end

    hhls_tracker #(
        .MAX_LINE (MAX_LINE)
    ) u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (proc_go),
        .data_byte (s1_data_reg),
        .last_byte (s1_last_reg),
        .result    (result)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc_go && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_go && s1_last_reg)
        begin
            out_reg <= result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_reg.status;
    assign field_len   = out_reg.field_len;
    assign value_start = out_reg.value_start;
    assign value_len   = out_reg.value_len;

    // Checks
    `HHLS_ASSERT_NEXT(a_result_held, out_valid_reg && out_stall, out_valid_reg, "result dropped while stalled")
    `HHLS_ASSERT_NEXT(a_result_loaded, proc_go && s1_last_reg, out_valid_reg, "last byte gave no result")
    `HHLS_ASSERT_IMP(a_ok_has_name, out_valid_reg && (out_reg.status == STATUS_OK), out_reg.field_len != '0, "ok status with empty name")
    `HHLS_ASSERT_IMP(a_err_zero, out_valid_reg && (out_reg.status != STATUS_OK), (out_reg.field_len == '0) && (out_reg.value_start == '0) && (out_reg.value_len == '0), "error result has nonzero fields")

endmodule

// ===== bench/hhls_line_scoreboard_pkg.sv =====
// Scoreboard for the header line splitter bench: a byte-serial line scanner
// that predicts one split per line, and the in-order check of each result.
// Depends on hhls_pkg.
`timescale 1ns / 1ps

package hhls_line_scoreboard_pkg;
    import hhls_pkg::*;

    // Line length limit; the bench builds the block with the same value
    localparam int LINE_LIMIT  = 8192;
    // Cap on printed mismatch lines
    localparam int MAX_REPORTS = 40;

    class header_split_scoreboard;
        // Scan state of the line in progress
        logic [13:0]  scan_pos;
        bit           colon_found;
        logic [12:0]  colon_at;
        bit           value_found;
        logic [13:0]  value_from;
        logic [13:0]  value_to;
        bit           overflowed;

        // Predicted splits, oldest first
        hhls_result_t expected_splits[$];
        int           mismatch_count;

        function new();
            mismatch_count = 0;
            clear_line();
        endfunction

        function void clear_line();
            scan_pos    = '0;
            colon_found = 1'b0;
            colon_at    = '0;
            value_found = 1'b0;
            value_from  = '0;
            value_to    = '0;
            overflowed  = 1'b0;
        endfunction

        static function bit blank_byte(logic [7:0] b);
            return (b == CHAR_SP) || (b == CHAR_HT);
        endfunction

        static function bit trim_byte(logic [7:0] b);
            return (b == CHAR_SP) || (b == CHAR_HT) || (b == CHAR_CR) || (b == CHAR_LF);
        endfunction

        function int pending();
            return expected_splits.size();
        endfunction

        // Advance the scan by one accepted byte; a final byte closes the line
        function void note_byte(logic [7:0] b, logic is_last);
            hhls_result_t split;
            logic [13:0]  p;
            p = scan_pos;
            if (overflowed || p >= LINE_LIMIT) begin
                // past the limit only the overflow is remembered
                overflowed = 1'b1;
            end
            else begin
                if (!colon_found) begin
                    if (b == CHAR_COLON) begin
                        colon_found = 1'b1;
                        colon_at    = p[12:0];
                    end
                end
                else if (!value_found) begin
                    if (!blank_byte(b)) begin
                        value_found = 1'b1;
                        value_from  = p;
                        value_to    = trim_byte(b) ? p : p + 14'd1;
                    end
                end
                else if (!trim_byte(b)) begin
                    value_to = p + 14'd1;
                end
                scan_pos = p + 14'd1;
            end

            if (is_last) begin
                split = '0;
                if (overflowed) begin
                    split.status = STATUS_TOO_LONG;
                end
                else if (!colon_found || colon_at == '0) begin
                    split.status = STATUS_NO_COLON;
                end
                else begin
                    split.status    = STATUS_OK;
                    split.field_len = colon_at;
                    if (value_found) begin
                        split.value_start = value_from;
                        split.value_len   = 13'(value_to - value_from);
                    end
                    else begin
                        // nothing but blanks after the colon
                        split.value_start = scan_pos;
                        split.value_len   = '0;
                    end
                end
                expected_splits.push_back(split);
                clear_line();
            end
        endfunction

        function void report_field(string what, logic [15:0] want, logic [15:0] got);
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        endfunction

        // Compare one accepted result transaction with the oldest prediction
        function void check_result(logic [1:0] st, logic [12:0] fl, logic [13:0] vs,
                                   logic [12:0] vl);
            hhls_result_t want;
            if (expected_splits.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result with no line pending, expected none, actual %0d/%0d/%0d/%0d",
                             $time, st, fl, vs, vl);
                return;
            end
            want = expected_splits.pop_front();
            if (st !== want.status)      report_field("status", want.status, st);
            if (fl !== want.field_len)   report_field("field_len", want.field_len, fl);
            if (vs !== want.value_start) report_field("value_start", want.value_start, vs);
            if (vl !== want.value_len)   report_field("value_len", want.value_len, vl);
        endfunction
    endclass

endpackage

// ===== bench/tb_http_header_line_splitter.sv =====
// Bench top for http_header_line_splitter: directed and random header lines
// with random idling on both channels, checked in order by the scoreboard.
// Depends on hhls_pkg, hhls_line_scoreboard_pkg and the block itself.
`timescale 1ns / 1ps

module tb_http_header_line_splitter;
    import hhls_pkg::*;
    import hhls_line_scoreboard_pkg::*;

    localparam int RANDOM_BYTES = 1150;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 40;
    localparam int TAIL_CYCLES  = 10;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [7:0]               data_byte;
    logic                     last_byte;
    logic                     out_valid;
    logic                     out_stall;
    logic [1:0]               status;
    logic [FIELD_LEN_W-1:0]   field_len;
    logic [VALUE_START_W-1:0] value_start;
    logic [VALUE_LEN_W-1:0]   value_len;

    header_split_scoreboard split_sb;
    logic [7:0]             line_buf[$];

    http_header_line_splitter #(
        .MAX_LINE    (LINE_LIMIT)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .field_len   (field_len),
        .value_start (value_start),
        .value_len   (value_len)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on run length
    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("end of test: mismatches");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] name_char();
        logic [7:0] c;
        c = 8'($urandom_range(33, 126));
        if (c == CHAR_COLON)
            c = 8'h41;
        return c;
    endfunction

    function automatic logic [7:0] blank_char();
        return ($urandom_range(0, 1) != 0) ? CHAR_SP : CHAR_HT;
    endfunction

    function automatic logic [7:0] trail_char();
        case ($urandom_range(0, 3))
            0:       return CHAR_SP;
            1:       return CHAR_HT;
            2:       return CHAR_CR;
            default: return CHAR_LF;
        endcase
    endfunction

    // Value bytes: mostly arbitrary, with embedded blanks, CR/LF and colons
    function automatic logic [7:0] value_char();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return blank_char();
        else if (r == 1)
            return trail_char();
        else if (r == 2)
            return CHAR_COLON;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // name, colon, leading blanks, value, trailing whitespace
    task automatic build_header(input int name_len, input int lead, input int val_len,
                                input int trail);
        line_buf.delete();
        repeat (name_len) line_buf.push_back(name_char());
        line_buf.push_back(CHAR_COLON);
        repeat (lead) line_buf.push_back(blank_char());
        repeat (val_len) line_buf.push_back(value_char());
        repeat (trail) line_buf.push_back(trail_char());
    endtask

    task automatic build_noise(input int len, input bit allow_colon);
        logic [7:0] b;
        line_buf.delete();
        repeat (len)
        begin
            b = 8'($urandom_range(0, 255));
            if (!allow_colon && b == CHAR_COLON)
                b = 8'hBA;
            line_buf.push_back(b);
        end
    endtask

    task automatic set_text(input string s);
        line_buf.delete();
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    // One input transaction; returns at the edge where it is taken, or after the idle gap that follows
    task automatic send_byte(input logic [7:0] b, input logic is_last, input int gap);
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= is_last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        split_sb.note_byte(b, is_last);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_line(input bit steady);
        int n;
        n = line_buf.size();
        for (int i = 0; i < n; i++)
            send_byte(line_buf[i], i == n - 1, steady ? 0 : pick_gap());
    endtask

    // Sender goes quiet until every predicted split has come out
    task automatic drain_results();
        in_valid <= 1'b0;
        while (split_sb.pending() != 0)
            @(posedge clk);
    endtask

    // Result side: check, then pick the next stall value
    initial
    begin : result_sink
        int stall_left;
        int free_left;
        int hold_left;
        int results_seen;
        bit hold_done;
        stall_left   = 0;
        free_left    = 0;
        hold_left    = 0;
        results_seen = 0;
        hold_done    = 1'b0;
        out_stall    = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                split_sb.check_result(status, field_len, value_start, value_len);
                results_seen++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                // one long hold-off so the block backs up into its input
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (free_left > 0)
            begin
                free_left--;
                out_stall <= 1'b0;
            end
            else
            begin
                free_left  = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(0, 6);
                stall_left = pick_gap();
                out_stall <= 1'b0;
            end
        end
    end

    // Stimulus
    initial
    begin : line_source
        int  random_bytes;
        int  r;
        bit  mid_done;
        split_sb     = new();
        random_bytes = 0;
        mid_done     = 1'b0;
        in_valid     = 1'b0;
        data_byte    = 8'h00;
        last_byte    = 1'b0;
        rst_n        = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed short lines
        set_text("Host: example.com\r\n");
        send_line(1'b0);
        set_text(":leading");          // colon first
        send_line(1'b0);
        set_text("NoColonHere");       // colon missing
        send_line(1'b0);
        set_text("Name:");             // colon as final byte
        send_line(1'b0);
        set_text("Name: \t ");         // only blanks after the colon
        send_line(1'b0);
        set_text("K:v:w:x");           // later colons are value bytes
        send_line(1'b0);
        set_text("X: \r\n");           // value starts on a CR
        send_line(1'b0);
        set_text("Key:  some value \t\r\n");
        send_line(1'b1);
        set_text(":");
        send_line(1'b0);
        set_text("a");
        send_line(1'b0);
        set_text("A:\tB\t:C  ");
        send_line(1'b0);
        // extreme byte values around the colon
        line_buf.delete();
        line_buf.push_back(8'h00);
        line_buf.push_back(8'hFF);
        line_buf.push_back(CHAR_COLON);
        line_buf.push_back(8'hFF);
        line_buf.push_back(8'h00);
        send_line(1'b0);
        drain_results();

        // Random lines, mostly well formed
        while (random_bytes < RANDOM_BYTES)
        begin
            if (!mid_done && random_bytes >= RANDOM_BYTES / 2)
            begin
                mid_done = 1'b1;
                drain_results();
            end
            r = $urandom_range(0, 99);
            if (r < 65)
                build_header($urandom_range(1, 12), $urandom_range(0, 3),
                             $urandom_range(0, 16), $urandom_range(0, 3));
            else if (r < 75)
                build_noise($urandom_range(1, 20), 1'b1);
            else if (r < 83)
                build_noise($urandom_range(1, 16), 1'b0);
            else if (r < 90)
                build_header(0, $urandom_range(0, 2), $urandom_range(0, 10),
                             $urandom_range(0, 2));
            else if (r < 95)
                build_header($urandom_range(1, 8), $urandom_range(0, 6), 0, 0);
            else
                build_header($urandom_range(1, 8), $urandom_range(0, 3), 0,
                             $urandom_range(1, 5));
            send_line($urandom_range(0, 3) == 0);
            random_bytes += line_buf.size();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (split_sb.mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== http_header_line_splitter.f =====
+incdir+design
design/hhls_pkg.sv
design/hhls_tracker.sv
design/http_header_line_splitter.sv
bench/hhls_line_scoreboard_pkg.sv
bench/tb_http_header_line_splitter.sv
